FILE: hw/rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types and constants of the strided DMA descriptor checker.
// ----------------------------------------------------------------------------
package sdc_pkg;

	// Number of descriptor levels carried in the input beat.
	localparam int FIELD_LEVELS = 3;
	// Default and largest supported number of checked levels.
	localparam int LEVELS_DEF   = 3;
	localparam int MAX_LEVELS   = 4;

	localparam int IN_DATA_W  = 608;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DDR_LOWER_BOUND = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USABLE_SCRATCH  = 1'd1;

	localparam logic [63:0] USABLE_SCRATCH_RESET = 64'd4194304;

	// Error codes, in check order; the first failing check wins.
	typedef enum logic [3:0] {
		ERR_NONE          = 4'd0,
		ERR_BYTES_ZERO    = 4'd1,
		ERR_INNER_ZERO    = 4'd2,
		ERR_INNER_BIG     = 4'd3,
		ERR_BELOW_BOUND   = 4'd4,
		ERR_ITER_NONPOS   = 4'd5,
		ERR_STRIDE_NEG    = 4'd6,
		ERR_RANGE_OVF     = 4'd7,
		ERR_EXT_OVF       = 4'd8,
		ERR_SCRATCH_OVF   = 4'd9,
		ERR_SCRATCH_FULL  = 4'd10,
		ERR_SCRATCH_WIDE  = 4'd11
	} err_t;

	// Per-descriptor fields that travel beside the level products.
	typedef struct packed {
		err_t        code;
		logic [63:0] addr;
		logic [63:0] bytes;
		logic [63:0] inner;
		logic [31:0] send_lo;
		logic        send_ovf;
		logic        send_full;
		logic        send_wide;
	} hdr_t;

endpackage

FILE: hw/rtl/sdc_level.sv
// ----------------------------------------------------------------------------
// sdc_level
// One descriptor level: sign checks and the exact (iterations-1)*stride
// product with a 64-bit overflow flag, over three pipeline stages.
// ----------------------------------------------------------------------------
module sdc_level
	import sdc_pkg::*;
(
	input  logic        clk,
	input  logic [2:0]  en,
	input  logic [63:0] iterations,
	input  logic [63:0] stride,
	output err_t        code,
	output logic [63:0] prod,
	output logic        prod_ovf
);

	logic [63:0] a_s1;
	logic [63:0] b_s1;
	err_t        code_s1;

	logic [63:0] cross_s2;
	logic [63:0] low_s2;
	logic        hh_s2;
	err_t        code_s2;

	logic [63:0] prod_s3;
	logic        ovf_s3;
	err_t        code_s3;

	logic        a_hi_nz;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [64:0] psum;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1 <= iterations - 64'd1;
			b_s1 <= stride;
			if (iterations == 64'd0 || iterations[63])
				code_s1 <= ERR_ITER_NONPOS;
			else if (stride[63])
				code_s1 <= ERR_STRIDE_NEG;
			else
				code_s1 <= ERR_NONE;
		end
	end

	// With both high halves nonzero the product is at least 2^64. Otherwise
	// only one cross term survives and a single 32x32 multiply covers it.
	assign a_hi_nz = (a_s1[63:32] != 32'd0);
	assign ma = a_hi_nz ? a_s1[63:32] : a_s1[31:0];
	assign mb = a_hi_nz ? b_s1[31:0]  : b_s1[63:32];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cross_s2 <= {32'd0, ma} * {32'd0, mb};
			low_s2   <= {32'd0, a_s1[31:0]} * {32'd0, b_s1[31:0]};
			hh_s2    <= a_hi_nz && (b_s1[63:32] != 32'd0);
			code_s2  <= code_s1;
		end
	end

	assign psum = {1'b0, cross_s2[31:0], 32'd0} + {1'b0, low_s2};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			prod_s3 <= psum[63:0];
			ovf_s3  <= hh_s2 || (cross_s2[63:32] != 32'd0) || psum[64];
			code_s3 <= code_s2;
		end
	end

	assign code     = code_s3;
	assign prod     = prod_s3;
	assign prod_ovf = ovf_s3;

endmodule

FILE: hw/rtl/sdc_tail.sv
// ----------------------------------------------------------------------------
// sdc_tail
// Running offset accumulation, one level per stage, then span, range end
// and the registered result.
// ----------------------------------------------------------------------------
module sdc_tail
	import sdc_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
)(
	input  logic          clk,
	input  logic [LEVELS+2:0] en,
	input  hdr_t          hdr,
	input  err_t          lvl_code [LEVELS],
	input  logic [63:0]   lvl_prod [LEVELS],
	input  logic          lvl_ovf  [LEVELS],
	output err_t          error_code,
	output logic [63:0]   ext_end,
	output logic [31:0]   scratch_end
);

	// Accumulation stages 1..LEVELS.
	hdr_t        st_hdr  [1:LEVELS];
	err_t        st_code [1:LEVELS];
	logic [63:0] st_off  [1:LEVELS];
	err_t        st_lc   [1:LEVELS][LEVELS];
	logic [63:0] st_p    [1:LEVELS][LEVELS];
	logic        st_pov  [1:LEVELS][LEVELS];

	// Sources feeding each accumulation stage.
	hdr_t        src_hdr  [LEVELS];
	err_t        src_code [LEVELS];
	logic [63:0] src_off  [LEVELS];
	err_t        src_lc   [LEVELS][LEVELS];
	logic [63:0] src_p    [LEVELS][LEVELS];
	logic        src_pov  [LEVELS][LEVELS];
	logic [64:0] acc_sum  [LEVELS];
	err_t        acc_code [LEVELS];

	hdr_t        hdr_sp;
	err_t        code_sp;
	logic [63:0] span_sp;
	hdr_t        hdr_mx;
	err_t        code_mx;
	logic [63:0] big_mx;

	logic [64:0] span_sum;
	logic [64:0] end_sum;
	err_t        end_code;

	always_comb begin
		for (int k = 0; k < LEVELS; k++) begin
			if (k == 0) begin
				src_hdr[k]  = hdr;
				src_code[k] = hdr.code;
				src_off[k]  = 64'd0;
				src_lc[k]   = lvl_code;
				src_p[k]    = lvl_prod;
				src_pov[k]  = lvl_ovf;
			end else begin
				src_hdr[k]  = st_hdr[k];
				src_code[k] = st_code[k];
				src_off[k]  = st_off[k];
				src_lc[k]   = st_lc[k];
				src_p[k]    = st_p[k];
				src_pov[k]  = st_pov[k];
			end
		end
		for (int k = 0; k < LEVELS; k++) begin
			acc_sum[k] = {1'b0, src_off[k]} + {1'b0, src_p[k][k]};
			if (src_code[k] != ERR_NONE)
				acc_code[k] = src_code[k];
			else if (src_lc[k][k] != ERR_NONE)
				acc_code[k] = src_lc[k][k];
			else if (src_pov[k][k] || acc_sum[k][64])
				acc_code[k] = ERR_RANGE_OVF;
			else
				acc_code[k] = ERR_NONE;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LEVELS; k++) begin
			if (en[k]) begin
				st_hdr[k+1]  <= src_hdr[k];
				st_code[k+1] <= acc_code[k];
				st_off[k+1]  <= acc_sum[k][63:0];
				st_lc[k+1]   <= src_lc[k];
				st_p[k+1]    <= src_p[k];
				st_pov[k+1]  <= src_pov[k];
			end
		end
	end

	// Span: largest run offset plus the inner run.
	assign span_sum = {1'b0, st_off[LEVELS]} + {1'b0, st_hdr[LEVELS].inner};

	always_ff @(posedge clk) begin
		if (en[LEVELS]) begin
			hdr_sp  <= st_hdr[LEVELS];
			span_sp <= span_sum[63:0];
			if (st_code[LEVELS] == ERR_NONE && span_sum[64])
				code_sp <= ERR_RANGE_OVF;
			else
				code_sp <= st_code[LEVELS];
		end
	end

	always_ff @(posedge clk) begin
		if (en[LEVELS+1]) begin
			hdr_mx  <= hdr_sp;
			code_mx <= code_sp;
			big_mx  <= (hdr_sp.bytes > span_sp) ? hdr_sp.bytes : span_sp;
		end
	end

	assign end_sum = {1'b0, hdr_mx.addr} + {1'b0, big_mx};

	always_comb begin
		priority if (code_mx != ERR_NONE)
			end_code = code_mx;
		else if (end_sum[64])
			end_code = ERR_EXT_OVF;
		else if (hdr_mx.send_ovf)
			end_code = ERR_SCRATCH_OVF;
		else if (hdr_mx.send_full)
			end_code = ERR_SCRATCH_FULL;
		else if (hdr_mx.send_wide)
			end_code = ERR_SCRATCH_WIDE;
		else
			end_code = ERR_NONE;
	end

	always_ff @(posedge clk) begin
		if (en[LEVELS+2]) begin
			error_code  <= end_code;
			ext_end     <= (end_code == ERR_NONE) ? end_sum[63:0] : 64'd0;
			scratch_end <= (end_code == ERR_NONE) ? hdr_mx.send_lo : 32'd0;
		end
	end

endmodule

FILE: hw/rtl/strided_dma_descriptor_check.sv
// ----------------------------------------------------------------------------
// strided_dma_descriptor_check
// Validates three-level strided DMA descriptors and returns an error code
// with the exclusive end of the external and scratchpad ranges.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Width  Contents
// s_*       in         608    one descriptor per beat
// m_*       out        104    error code, external end, scratchpad end
// cfg_*     in         1+64   register writes, index 0 lower bound, 1 capacity
//
// Every beat passes LEVELS + 6 stages: decode, multiply, product forming, one
// accumulation stage per level, span, max select and the end add, the last
// of which is the result register. A new descriptor is accepted every cycle
// unless an output stall has filled every stage.
// arst_n clears the stage valid bits and loads the register reset values.
// A stall at the output backs up only as far as the first empty stage, so
// bubbles are squeezed out and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module strided_dma_descriptor_check
	import sdc_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
)(
	input  logic                   clk,
	input  logic                   arst_n,

	// s_tdata fields from bit 0 up: ext_address[64], scratch_offset[32],
	// total_bytes[64], inner_run_bytes[64], stride_0..stride_2[64 each],
	// iterations_0..iterations_2[64 each].
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,

	// m_tdata fields from bit 0 up: error_code[4], ext_end[64],
	// scratch_end[32], then four zero bits.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,

	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int NST = LEVELS + 6;

	// Configuration registers.
	logic [63:0] ddr_lower_bound_q;
	logic [63:0] usable_scratch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ddr_lower_bound_q <= 64'd0;
			usable_scratch_q  <= USABLE_SCRATCH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DDR_LOWER_BOUND: ddr_lower_bound_q <= cfg_wdata;
				CFG_USABLE_SCRATCH:  usable_scratch_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage valid bits and the stall chain. A stage may load when it is empty
	// or when the stage after it loads in the same cycle.
	logic [NST:1]   v_q;
	logic [NST:1]   v_in;
	logic [NST+1:1] en;

	assign v_in = {v_q[NST-1:1], s_tvalid};

	always_comb begin
		en[NST+1] = m_tready;
		for (int k = NST; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NST; k++)
				if (en[k])
					v_q[k] <= v_in[k];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[NST];

	// Input field views.
	logic [63:0] in_addr;
	logic [31:0] in_spm;
	logic [63:0] in_bytes;
	logic [63:0] in_inner;

	assign in_addr  = s_tdata[63:0];
	assign in_spm   = s_tdata[95:64];
	assign in_bytes = s_tdata[159:96];
	assign in_inner = s_tdata[223:160];

	// Header stages: the simple checks and the scratchpad end run beside the
	// level multipliers.
	hdr_t        hdr_s1;
	logic [64:0] send_s1;
	hdr_t        hdr_s2_d;
	hdr_t        hdr_s2;
	hdr_t        hdr_s3;
	err_t        early_code;

	always_comb begin
		priority if (in_bytes == 64'd0)
			early_code = ERR_BYTES_ZERO;
		else if (in_inner == 64'd0)
			early_code = ERR_INNER_ZERO;
		else if (in_inner > in_bytes)
			early_code = ERR_INNER_BIG;
		else if (in_addr < ddr_lower_bound_q)
			early_code = ERR_BELOW_BOUND;
		else
			early_code = ERR_NONE;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hdr_s1.code      <= early_code;
			hdr_s1.addr      <= in_addr;
			hdr_s1.bytes     <= in_bytes;
			hdr_s1.inner     <= in_inner;
			hdr_s1.send_lo   <= 32'd0;
			hdr_s1.send_ovf  <= 1'b0;
			hdr_s1.send_full <= 1'b0;
			hdr_s1.send_wide <= 1'b0;
			send_s1          <= {33'd0, in_spm} + {1'b0, in_bytes};
		end
	end

	// The scratchpad flags are filled in on the way into stage two.
	always_comb begin
		hdr_s2_d           = hdr_s1;
		hdr_s2_d.send_lo   = send_s1[31:0];
		hdr_s2_d.send_ovf  = send_s1[64];
		hdr_s2_d.send_full = send_s1[63:0] > usable_scratch_q;
		hdr_s2_d.send_wide = send_s1[63:32] != 32'd0;
	end

	always_ff @(posedge clk) begin
		if (en[2])
			hdr_s2 <= hdr_s2_d;
		if (en[3])
			hdr_s3 <= hdr_s2;
	end

	// One product unit per level; levels past the carried three are neutral.
	err_t        lvl_code [LEVELS];
	logic [63:0] lvl_prod [LEVELS];
	logic        lvl_ovf  [LEVELS];

	for (genvar i = 0; i < LEVELS; i++) begin : g_level
		logic [63:0] iter_i;
		logic [63:0] stride_i;

		if (i < FIELD_LEVELS) begin : g_field
			assign stride_i = s_tdata[224 + 64*i +: 64];
			assign iter_i   = s_tdata[416 + 64*i +: 64];
		end else begin : g_pad
			assign stride_i = 64'd0;
			assign iter_i   = 64'd1;
		end

		sdc_level u_level (
			.clk        (clk),
			.en         (en[3:1]),
			.iterations (iter_i),
			.stride     (stride_i),
			.code       (lvl_code[i]),
			.prod       (lvl_prod[i]),
			.prod_ovf   (lvl_ovf[i])
		);
	end

	err_t        res_code;
	logic [63:0] res_ext_end;
	logic [31:0] res_scratch_end;

	sdc_tail #(
		.LEVELS (LEVELS)
	) u_tail (
		.clk         (clk),
		.en          (en[NST:4]),
		.hdr         (hdr_s3),
		.lvl_code    (lvl_code),
		.lvl_prod    (lvl_prod),
		.lvl_ovf     (lvl_ovf),
		.error_code  (res_code),
		.ext_end     (res_ext_end),
		.scratch_end (res_scratch_end)
	);

	assign m_tdata = {4'd0, res_scratch_end, res_ext_end, res_code};

	// A failed descriptor never reports a range.
	a_err_zero_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_code != ERR_NONE) |-> (res_ext_end == 64'd0 &&
		res_scratch_end == 32'd0))
		else $error("error result carries a nonzero range end");

	// Backpressure reaches the input only when every stage is occupied.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&v_q))
		else $error("input stalled while a stage is empty");

	// An accepted beat always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_q[1])
		else $error("accepted descriptor lost at stage one");

	// A successful result has a scratchpad end and an external end no smaller than one byte.
	a_ok_scratch: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_code == ERR_NONE) |-> (res_scratch_end != 32'd0 &&
		res_ext_end != 64'd0))
		else $error("successful result with an empty range");

endmodule

FILE: test/strided_dma_descriptor_check_test.sv
// ----------------------------------------------------------------------------
// strided_dma_descriptor_check_test
// Self-checking bench for the strided DMA descriptor checker. A short table of
// hand-picked descriptors and register writes comes first, then several
// phases of random descriptors under different register settings. Every
// result beat is compared field by field against a typed verdict or an in-bench predictor.
// ----------------------------------------------------------------------------
module strided_dma_descriptor_check_test;
	import sdc_pkg::*;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN  = 64'h8000_0000_0000_0000;

	// The pipeline is LEVELS + 6 stages deep at the default level count.
	localparam int PIPE_LATENCY     = LEVELS_DEF + 6;
	localparam int ITEMS_PER_PHASE  = 300;
	localparam int PHASES           = 6;
	localparam int LONG_HOLD_CYCLES = 400;
	// No correct run goes this long without a beat on either side; the
	// longest quiet stretch is the long receiver hold plus a pipeline drain.
	localparam int STALL_LIMIT      = 4000;
	localparam int MAX_PRINTED      = 40;

	// One descriptor as it travels in s_tdata.
	typedef struct packed {
		logic [63:0]      ext_address;
		logic [31:0]      scratch_offset;
		logic [63:0]      total_bytes;
		logic [63:0]      inner_run_bytes;
		logic [2:0][63:0] stride;
		logic [2:0][63:0] iterations;
	} descriptor_t;

	// What the block should answer for one descriptor.
	typedef struct packed {
		err_t        code;
		logic [63:0] ext_end;
		logic [31:0] scratch_end;
	} verdict_t;

	typedef enum logic [1:0] {
		ROW_PREDICTED,
		ROW_TYPED,
		ROW_CONFIG
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [63:0]           reg_value;
		descriptor_t           desc;
		verdict_t              typed_verdict;
	} stimulus_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Shadow copies of the two registers, updated on every write.
	logic [63:0] lower_bound_setting = 64'd0;
	logic [63:0] capacity_setting    = USABLE_SCRATCH_RESET;

	verdict_t      awaited_verdicts [$];
	stimulus_row_t directed_rows [$];

	int descriptors_sent = 0;
	int results_checked  = 0;
	int failures         = 0;
	int idle_cycles      = 0;
	int settings_used    = 1;
	int holds_requested  = 0;
	int holds_served     = 0;
	int code_seen [16];

	strided_dma_descriptor_check u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Helpers for building descriptors and verdicts.
	// ------------------------------------------------------------------

	function automatic descriptor_t descr(
		logic [63:0] addr, logic [31:0] spm, logic [63:0] bytes, logic [63:0] inner,
		logic [63:0] s0, logic [63:0] s1, logic [63:0] s2,
		logic [63:0] i0, logic [63:0] i1, logic [63:0] i2);
		descriptor_t d;
		d.ext_address     = addr;
		d.scratch_offset  = spm;
		d.total_bytes     = bytes;
		d.inner_run_bytes = inner;
		d.stride          = {s2, s1, s0};
		d.iterations      = {i2, i1, i0};
		return d;
	endfunction

	function automatic verdict_t verdict(err_t code, logic [63:0] ext, logic [31:0] spm);
		verdict_t v;
		v.code        = code;
		v.ext_end     = ext;
		v.scratch_end = spm;
		return v;
	endfunction

	// Fields sit back to back from bit 0 up, ext_address lowest and the
	// level-2 iteration count highest.
	function automatic logic [IN_DATA_W-1:0] pack_descriptor(descriptor_t d);
		return {d.iterations, d.stride, d.inner_run_bytes, d.total_bytes,
			d.scratch_offset, d.ext_address};
	endfunction

	// ------------------------------------------------------------------
	// Predictor. The checks run in a fixed order and the first one that
	// fails names the error; ends are zero on any error. Every sum is
	// formed one bit wider than its operands (the level offsets on 128
	// bits) so that an overflow shows up as a set upper bit.
	// ------------------------------------------------------------------
	function automatic verdict_t verdict_for(descriptor_t d);
		logic [127:0] reach;
		logic [64:0]  sum;
		logic [63:0]  span;
		logic [63:0]  extent;
		logic [63:0]  ext_limit;
		if (d.total_bytes == 64'd0)
			return verdict(ERR_BYTES_ZERO, '0, '0);
		if (d.inner_run_bytes == 64'd0)
			return verdict(ERR_INNER_ZERO, '0, '0);
		if (d.inner_run_bytes > d.total_bytes)
			return verdict(ERR_INNER_BIG, '0, '0);
		if (d.ext_address < lower_bound_setting)
			return verdict(ERR_BELOW_BOUND, '0, '0);
		reach = '0;
		// Level by level: count first, then stride sign, then the running
		// offset of the last run in that level.
		for (int lv = 0; lv < FIELD_LEVELS; lv++) begin
			if ($signed(d.iterations[lv]) <= 0)
				return verdict(ERR_ITER_NONPOS, '0, '0);
			if (d.stride[lv][63])
				return verdict(ERR_STRIDE_NEG, '0, '0);
			reach = ({64'd0, d.iterations[lv]} - 128'd1) * {64'd0, d.stride[lv]} + reach;
			if (reach[127:64] != '0)
				return verdict(ERR_RANGE_OVF, '0, '0);
		end
		sum = {1'b0, reach[63:0]} + {1'b0, d.inner_run_bytes};
		if (sum[64])
			return verdict(ERR_RANGE_OVF, '0, '0);
		span = sum[63:0];
		extent = (d.total_bytes > span) ? d.total_bytes : span;
		sum = {1'b0, d.ext_address} + {1'b0, extent};
		if (sum[64])
			return verdict(ERR_EXT_OVF, '0, '0);
		ext_limit = sum[63:0];
		sum = {33'd0, d.scratch_offset} + {1'b0, d.total_bytes};
		if (sum[64])
			return verdict(ERR_SCRATCH_OVF, '0, '0);
		if (sum[63:0] > capacity_setting)
			return verdict(ERR_SCRATCH_FULL, '0, '0);
		if (sum[63:32] != '0)
			return verdict(ERR_SCRATCH_WIDE, '0, '0);
		return verdict(ERR_NONE, ext_limit, sum[31:0]);
	endfunction

	// ------------------------------------------------------------------
	// Random values and idle gaps.
	// ------------------------------------------------------------------

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Corners of both signed and unsigned ranges, with random words mixed
	// in.
	function automatic logic [63:0] edgy64();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return 64'd1;
			2: return ALL_ONES;
			3: return NEG_MIN;
			4: return POS_MAX;
			default: return rand64();
		endcase
	endfunction

	// Most gaps are zero or short, a few are long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// A random descriptor. Most are well formed with small level counts and
	// strides so that they reach the end computation; about a third of those
	// then get one field broken, and a tenth of all are pure noise.
	function automatic descriptor_t random_descriptor();
		descriptor_t d;
		logic [63:0] reach;
		logic [63:0] runs;
		logic [63:0] room;
		int          lv;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			d = descr(edgy64(), $urandom, edgy64(), edgy64(), edgy64(), edgy64(),
				edgy64(), edgy64(), edgy64(), edgy64());
			return d;
		end
		reach = 64'd0;
		runs = 64'd1;
		for (int n = 0; n < FIELD_LEVELS; n++) begin
			d.iterations[n] = 64'($urandom_range(1, 6));
			d.stride[n] = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 2048));
			reach = reach + (d.iterations[n] - 64'd1) * d.stride[n];
			runs = runs * d.iterations[n];
		end
		d.inner_run_bytes = 64'($urandom_range(1, 256));
		case ($urandom_range(0, 3))
			0, 1: d.total_bytes = d.inner_run_bytes * runs;
			2: d.total_bytes = d.inner_run_bytes + 64'($urandom_range(0, 8192));
			default: d.total_bytes = reach + d.inner_run_bytes + 64'($urandom_range(0, 64));
		endcase
		d.ext_address = lower_bound_setting + 64'($urandom);
		if (d.ext_address < lower_bound_setting)
			d.ext_address = lower_bound_setting;
		// Keep the scratchpad range inside the capacity where it can be.
		if (capacity_setting >= d.total_bytes) begin
			room = capacity_setting - d.total_bytes;
			if (room > 64'hFFFF_FFFF)
				room = 64'hFFFF_FFFF;
			d.scratch_offset = 32'(64'($urandom) % (room + 64'd1));
		end else begin
			d.scratch_offset = $urandom;
		end
		if (roll < 70)
			return d;
		lv = $urandom_range(0, FIELD_LEVELS - 1);
		case ($urandom_range(0, 9))
			0: d.total_bytes = 64'd0;
			1: d.inner_run_bytes = 64'd0;
			2: d.inner_run_bytes = d.total_bytes + 64'd1 + 64'($urandom_range(0, 100));
			3: begin
				if (lower_bound_setting != 64'd0)
					d.ext_address = lower_bound_setting - 64'd1 - rand64() % lower_bound_setting;
				else
					d.ext_address = rand64();
			end
			4: d.iterations[lv] = $urandom_range(0, 1) ? 64'd0 : (rand64() | NEG_MIN);
			5: d.stride[lv] = rand64() | NEG_MIN;
			6: begin
				d.stride[lv] = rand64() & POS_MAX;
				d.iterations[lv] = 64'($urandom_range(2, 1000));
			end
			7: d.ext_address = ALL_ONES - 64'($urandom_range(0, 4096));
			8: d.scratch_offset = 32'hFFFF_FFFF - $urandom_range(0, 4096);
			default: d.total_bytes = rand64() | 64'h1;
		endcase
		return d;
	endfunction

	// ------------------------------------------------------------------
	// Directed table rows.
	// ------------------------------------------------------------------

	function automatic void add_predicted(descriptor_t d);
		stimulus_row_t r;
		r.kind = ROW_PREDICTED;
		r.reg_index = '0;
		r.reg_value = '0;
		r.desc = d;
		r.typed_verdict = verdict(ERR_NONE, '0, '0);
		directed_rows.push_back(r);
	endfunction

	function automatic void add_typed(descriptor_t d, err_t code, logic [63:0] ext,
		logic [31:0] spm);
		stimulus_row_t r;
		r.kind = ROW_TYPED;
		r.reg_index = '0;
		r.reg_value = '0;
		r.desc = d;
		r.typed_verdict = verdict(code, ext, spm);
		directed_rows.push_back(r);
	endfunction

	function automatic void add_config(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
		stimulus_row_t r;
		r.kind = ROW_CONFIG;
		r.reg_index = index;
		r.reg_value = value;
		r.desc = '0;
		r.typed_verdict = verdict(ERR_NONE, '0, '0);
		directed_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Driving tasks. All of them are entered and left at a rising edge.
	// Handshakes are sampled at the falling edge, where inputs and the
	// block's outputs are settled, and the beat moves at the next rise.
	// ------------------------------------------------------------------

	task automatic offer_descriptor(input descriptor_t d, input verdict_t outcome,
		input int gap);
		bit taken;
		s_tdata <= pack_descriptor(d);
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		awaited_verdicts.push_back(outcome);
		descriptors_sent++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding result. Every descriptor
	// gives exactly one result, so an empty queue means an empty pipeline.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
		input logic [63:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (index == CFG_DDR_LOWER_BOUND)
			lower_bound_setting = value;
		else if (index == CFG_USABLE_SCRATCH)
			capacity_setting = value;
	endtask

	task automatic report_mismatch(input string what);
		if (failures < MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $time, what);
		failures++;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: m_tready idles at random, sometimes stays high for a
	// long stretch, and on request holds off for a long time so that the
	// pipeline fills and pushes back on the sender.
	// ------------------------------------------------------------------
	initial begin : ready_driver
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holds_served < holds_requested) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				holds_served++;
			end else if ($urandom_range(0, 9) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(30, 150)) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker. m_tdata holds, from bit 0 up, the error code, the
	// external end, the scratchpad end and four zero pad bits.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : result_check
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			code_seen[m_tdata[3:0]]++;
			if (awaited_verdicts.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing outstanding: %h",
					m_tdata));
			end else begin
				want = awaited_verdicts.pop_front();
				if (m_tdata[3:0] != want.code)
					report_mismatch($sformatf("result %0d error_code %0d, want %0d",
						results_checked, m_tdata[3:0], want.code));
				if (m_tdata[67:4] != want.ext_end)
					report_mismatch($sformatf("result %0d ext_end %h, want %h",
						results_checked, m_tdata[67:4], want.ext_end));
				if (m_tdata[99:68] != want.scratch_end)
					report_mismatch($sformatf("result %0d scratch_end %h, want %h",
						results_checked, m_tdata[99:68], want.scratch_end));
				if (m_tdata[103:100] != 4'd0)
					report_mismatch($sformatf("result %0d pad bits %b not zero",
						results_checked, m_tdata[103:100]));
			end
		end
	end

	// Watchdog: ends the run when neither side has moved a beat for too long.
	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles, %0d results outstanding.",
					idle_cycles, awaited_verdicts.size());
				$display("FAIL strided_dma_descriptor_check");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [63:0] phase_lower [PHASES];
		logic [63:0] phase_capacity [PHASES];
		descriptor_t d;
		bit          burst;
		string       seen_list;

		// The directed table. It starts under the reset values of both
		// registers, so its first rows also check those.
		add_typed(descr(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), ERR_BYTES_ZERO, 0, 0);
		add_typed(descr(0, 0, 1, 0, 0, 0, 0, 1, 1, 1), ERR_INNER_ZERO, 0, 0);
		add_typed(descr(0, 0, 1, 2, 0, 0, 0, 1, 1, 1), ERR_INNER_BIG, 0, 0);
		add_typed(descr(64'h1000, 32'h10, 64, 64, 0, 0, 0, 1, 1, 1),
			ERR_NONE, 64'h1040, 32'h50);
		add_typed(descr(0, 0, 1, 1, 0, 0, 0, 0, 1, 1), ERR_ITER_NONPOS, 0, 0);
		add_typed(descr(0, 0, 1, 1, 0, 0, 0, NEG_MIN, 1, 1), ERR_ITER_NONPOS, 0, 0);
		add_typed(descr(0, 0, 1, 1, ALL_ONES, 0, 0, 1, 1, 1), ERR_STRIDE_NEG, 0, 0);
		// Level 1 has both a zero count and a negative stride: the count wins.
		add_typed(descr(0, 0, 1, 1, 0, NEG_MIN, 0, 1, 0, 1), ERR_ITER_NONPOS, 0, 0);
		add_typed(descr(0, 0, 1, 1, 0, 0, NEG_MIN, 1, 1, POS_MAX), ERR_STRIDE_NEG, 0, 0);
		// Offset of a single level runs past 64 bits.
		add_typed(descr(0, 0, 1, 1, POS_MAX, 0, 0, POS_MAX, 1, 1), ERR_RANGE_OVF, 0, 0);
		// Offsets reach 2^64-2; two inner bytes overflow, one just fits.
		add_typed(descr(0, 0, 2, 2, POS_MAX, POS_MAX, 0, 2, 2, 1), ERR_RANGE_OVF, 0, 0);
		add_predicted(descr(0, 0, 1, 1, POS_MAX, POS_MAX, 0, 2, 2, 1));
		add_typed(descr(ALL_ONES, 0, 1, 1, 0, 0, 0, 1, 1, 1), ERR_EXT_OVF, 0, 0);
		add_typed(descr(0, 32'hFFFF_FFFF, ALL_ONES, 1, 0, 0, 0, 1, 1, 1),
			ERR_SCRATCH_OVF, 0, 0);
		add_typed(descr(0, 0, 4194305, 1, 0, 0, 0, 1, 1, 1), ERR_SCRATCH_FULL, 0, 0);
		// Scratchpad end exactly at the capacity is still allowed.
		add_typed(descr(64'h2000, 32'h3F_FFF0, 16, 16, 0, 0, 0, 1, 1, 1),
			ERR_NONE, 64'h2010, 32'h40_0000);
		// Strided span larger than the byte count sets the external end.
		add_predicted(descr(64'h8000, 32'h100, 64, 16, 256, 4096, 0, 4, 3, POS_MAX));
		add_config(CFG_DDR_LOWER_BOUND, 64'h1000);
		add_typed(descr(64'hFFF, 0, 1, 1, 0, 0, 0, 1, 1, 1), ERR_BELOW_BOUND, 0, 0);
		add_typed(descr(64'h1000, 0, 1, 1, 0, 0, 0, 1, 1, 1), ERR_NONE, 64'h1001, 1);
		add_config(CFG_DDR_LOWER_BOUND, ALL_ONES);
		add_config(CFG_USABLE_SCRATCH, ALL_ONES);
		add_typed(descr(ALL_ONES - 1, 0, 1, 1, 0, 0, 0, 1, 1, 1), ERR_BELOW_BOUND, 0, 0);
		add_typed(descr(ALL_ONES, 0, 1, 1, 0, 0, 0, 1, 1, 1), ERR_EXT_OVF, 0, 0);
		add_config(CFG_DDR_LOWER_BOUND, 64'd0);
		// With unlimited capacity the 32-bit scratchpad limit is what bites.
		add_typed(descr(0, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 1, 1, 1), ERR_SCRATCH_WIDE, 0, 0);
		add_typed(descr(0, 32'hFFFF_FFF0, 15, 15, 0, 0, 0, 1, 1, 1),
			ERR_NONE, 64'd15, 32'hFFFF_FFFF);
		add_config(CFG_USABLE_SCRATCH, 64'd0);
		add_typed(descr(0, 0, 1, 1, 0, 0, 0, 1, 1, 1), ERR_SCRATCH_FULL, 0, 0);

		// Register settings for the random phases, extremes among them.
		phase_lower[0] = 64'd0;
		phase_capacity[0] = USABLE_SCRATCH_RESET;
		phase_lower[1] = {24'd0, 8'($urandom_range(0, 255)), $urandom};
		phase_capacity[1] = {31'd0, 1'($urandom_range(0, 1)), $urandom};
		phase_lower[2] = 64'd0;
		phase_capacity[2] = ALL_ONES;
		phase_lower[3] = rand64();
		phase_capacity[3] = ALL_ONES;
		phase_lower[4] = 64'h1000;
		phase_capacity[4] = 64'h0000_0000_FFFF_FFFF;
		phase_lower[5] = ALL_ONES;
		phase_capacity[5] = 64'd0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			case (directed_rows[n].kind)
				ROW_CONFIG: begin
					drain_results();
					write_register(directed_rows[n].reg_index, directed_rows[n].reg_value);
					settings_used++;
				end
				ROW_TYPED: begin
					offer_descriptor(directed_rows[n].desc, directed_rows[n].typed_verdict,
						pick_gap());
				end
				default: begin
					offer_descriptor(directed_rows[n].desc,
						verdict_for(directed_rows[n].desc), pick_gap());
				end
			endcase
		end

		// Random phases. Each one starts from an empty pipeline, so the
		// sender pauses here until every result has come back.
		burst = 1'b0;
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			write_register(CFG_DDR_LOWER_BOUND, phase_lower[phase]);
			write_register(CFG_USABLE_SCRATCH, phase_capacity[phase]);
			settings_used++;
			// In the second phase the receiver holds off for a long time
			// while the sender keeps pushing with no gaps.
			if (phase == 1)
				holds_requested++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 64 == 0)
					burst = ($urandom_range(0, 3) == 0);
				d = random_descriptor();
				offer_descriptor(d, verdict_for(d),
					(burst || (phase == 1 && n < 150)) ? 0 : pick_gap());
			end
		end

		drain_results();
		// Anything the block sends after this point has no expectation.
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		seen_list = "";
		for (int c = 0; c < 16; c++)
			if (code_seen[c] != 0)
				seen_list = {seen_list, $sformatf(" %0d:%0d", c, code_seen[c])};
		$display("Sent %0d descriptors under %0d register settings; %0d results compared, %0d mismatches.",
			descriptors_sent, settings_used, results_checked, failures);
		$display("Error codes returned (code:count):%s", seen_list);
		if (failures == 0 && awaited_verdicts.size() == 0) begin
			$display("PASS strided_dma_descriptor_check");
		end else begin
			$display("FAIL strided_dma_descriptor_check");
		end
		$finish;
	end

endmodule
